// ===== rtl/core/mdcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdcr_pkg
// Shared types and constants for the microphone DC removal, gain and frame
// statistics block.
// ----------------------------------------------------------------------------
package mdcr_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int GAIN_W        = 7;
  localparam int ACC_W         = 26;
  // Count width covers the largest allowed frame length (1024)
  localparam int CNT_W         = 11;
  localparam int DEF_MAX_FRAME = 1024;
  localparam int DEF_Q_DEPTH   = 4;
  localparam int DC_SHIFT      = 7;
  localparam int PROD_W        = SAMPLE_W + 1 + GAIN_W + 1;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = GAIN_W'(1);
  localparam logic [ACC_W-1:0]    ACC_MAX    = {ACC_W{1'b1}};
  localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S16_MIN = 16'sh8000;

  // One classified sample, as handed from the front to the back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic signed [SAMPLE_W-1:0] fmin;
    logic signed [SAMPLE_W-1:0] fmax;
    logic [ACC_W-1:0]           delta;
    logic [CNT_W-1:0]           count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CALC,
    BK_ACCUM,
    BK_DIVIDE,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/mdcr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdcr_front
// Accepts raw samples, tracks raw min/max, neighbor deltas and the sample
// count, marks frame ends and pushes classified items into the queue.
// ----------------------------------------------------------------------------
module mdcr_front #(
  parameter int MAX_FRAME = mdcr_pkg::DEF_MAX_FRAME
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [mdcr_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic                                frame_last,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output mdcr_pkg::entry_t                         q_entry
);
  import mdcr_pkg::*;

  localparam logic [CNT_W-1:0] FRAME_LIMIT = CNT_W'(MAX_FRAME);

  logic signed [SAMPLE_W-1:0] prev_raw;
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SAMPLE_W-1:0] run_max;
  logic [ACC_W-1:0]           delta_acc;
  logic [CNT_W-1:0]           count;

  logic signed [SAMPLE_W-1:0] min_next;
  logic signed [SAMPLE_W-1:0] max_next;
  logic [ACC_W-1:0]           delta_next;
  logic [CNT_W-1:0]           count_next;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          diff_abs;
  logic [ACC_W:0]             delta_sum;
  logic                       frame_end;

  assign full   = q_full;
  assign q_push = push && !q_full;

  // Classify the incoming sample
  always_comb begin
    min_next   = (sample_in < run_min) ? sample_in : run_min;
    max_next   = (sample_in > run_max) ? sample_in : run_max;
    diff       = {sample_in[SAMPLE_W-1], sample_in} - {prev_raw[SAMPLE_W-1], prev_raw};
    diff_abs   = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
    delta_sum  = {1'b0, delta_acc} + (ACC_W+1)'(diff_abs);
    if (count == '0) begin
      delta_next = delta_acc;
    end else if (delta_sum[ACC_W]) begin
      delta_next = ACC_MAX;
    end else begin
      delta_next = delta_sum[ACC_W-1:0];
    end
    count_next = count + CNT_W'(1);
    frame_end  = frame_last || (count_next >= FRAME_LIMIT);
  end

  always_comb begin
    q_entry.sample = sample_in;
    q_entry.last   = frame_end;
    q_entry.fmin   = min_next;
    q_entry.fmax   = max_next;
    q_entry.delta  = delta_next;
    q_entry.count  = count_next;
  end

  // Advance per-frame state; clear it at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw  <= '0;
      run_min   <= S16_MAX;
      run_max   <= S16_MIN;
      delta_acc <= '0;
      count     <= '0;
    end else if (q_push) begin
      if (frame_end) begin
        prev_raw  <= '0;
        run_min   <= S16_MAX;
        run_max   <= S16_MIN;
        delta_acc <= '0;
        count     <= '0;
      end else begin
        prev_raw  <= sample_in;
        run_min   <= min_next;
        run_max   <= max_next;
        delta_acc <= delta_next;
        count     <= count_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mdcr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdcr_queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module mdcr_queue #(
  parameter int WIDTH = mdcr_pkg::ENTRY_W,
  parameter int DEPTH = mdcr_pkg::DEF_Q_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  q_full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  q_empty
);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(DEPTH);

  logic [WIDTH-1:0]  slots [DEPTH];
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (fill == FULL_CNT);
  assign q_empty = (fill == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  // Store written items
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + FILL_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mdcr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdcr_back
// Runs DC removal, gain and saturation on each queued item, accumulates
// absolute output, divides for the frame mean and holds the result register.
// ----------------------------------------------------------------------------
module mdcr_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 gain_we,
  input  wire logic [mdcr_pkg::GAIN_W-1:0]          gain,
  input  wire mdcr_pkg::entry_t                     q_entry,
  input  wire logic                                 q_empty,
  output logic                                      q_pop,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic signed [mdcr_pkg::SAMPLE_W-1:0]      sample_out,
  output logic                                      frame_done,
  output logic signed [mdcr_pkg::SAMPLE_W-1:0]      frame_min,
  output logic signed [mdcr_pkg::SAMPLE_W-1:0]      frame_max,
  output logic [mdcr_pkg::ACC_W-1:0]                frame_delta_sum,
  output logic [mdcr_pkg::SAMPLE_W-1:0]             frame_mean_abs
);
  import mdcr_pkg::*;

  localparam int DCNT_W = $clog2(ACC_W + 1);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(ACC_W - 1);
  localparam logic signed [PROD_W-1:0] PROD_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] PROD_MIN = -PROD_W'(32768);

  back_state_t state;
  back_state_t state_next;

  logic [GAIN_W-1:0]          gain_reg;
  entry_t                     cur;
  logic signed [SAMPLE_W-1:0] dc_est;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] amp;
  logic [ACC_W-1:0]           abs_acc;
  logic [ACC_W-1:0]           dvd;
  logic [CNT_W-1:0]           rem;
  logic [CNT_W-1:0]           divisor;
  logic [DCNT_W-1:0]          div_cnt;
  logic                       out_valid;
  logic                       out_free;
  logic                       load_out;

  logic signed [SAMPLE_W:0]   dc_diff;
  logic signed [SAMPLE_W:0]   dc_step;
  logic signed [SAMPLE_W-1:0] dc_next;
  logic signed [SAMPLE_W:0]   centered;
  logic signed [SAMPLE_W-1:0] amp_next;
  logic [SAMPLE_W:0]          mag;
  logic [ACC_W:0]             abs_sum;
  logic [ACC_W-1:0]           abs_next;
  logic [CNT_W:0]             trial;
  logic                       trial_ge;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  // DC estimate update and centering; step truncates toward zero
  always_comb begin
    dc_diff  = {cur.sample[SAMPLE_W-1], cur.sample} - {dc_est[SAMPLE_W-1], dc_est};
    dc_step  = dc_diff[SAMPLE_W] ? ((dc_diff + (SAMPLE_W+1)'(127)) >>> DC_SHIFT)
                                 : (dc_diff >>> DC_SHIFT);
    dc_next  = dc_est + dc_step[SAMPLE_W-1:0];
    centered = {cur.sample[SAMPLE_W-1], cur.sample} - {dc_next[SAMPLE_W-1], dc_next};
  end

  // Saturate product and accumulate magnitude
  always_comb begin
    if (prod > PROD_MAX) begin
      amp_next = S16_MAX;
    end else if (prod < PROD_MIN) begin
      amp_next = S16_MIN;
    end else begin
      amp_next = prod[SAMPLE_W-1:0];
    end
    mag      = amp_next[SAMPLE_W-1] ? (SAMPLE_W+1)'(-{amp_next[SAMPLE_W-1], amp_next})
                                    : {1'b0, amp_next};
    abs_sum  = {1'b0, abs_acc} + (ACC_W+1)'(mag);
    abs_next = abs_sum[ACC_W] ? ACC_MAX : abs_sum[ACC_W-1:0];
  end

  // Restoring division step, one quotient bit per cycle
  always_comb begin
    trial    = {rem, dvd[ACC_W-1]};
    trial_ge = (trial >= {1'b0, divisor});
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) state_next = BK_CALC;
      end
      BK_CALC: state_next = BK_ACCUM;
      BK_ACCUM: begin
        state_next = cur.last ? BK_DIVIDE : BK_EMIT;
      end
      BK_DIVIDE: begin
        if (div_cnt == DIV_LAST) state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE:  q_pop    = !q_empty;
      BK_EMIT:  load_out = out_free;
      default: begin
        q_pop    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_reg <= GAIN_RESET;
    end else if (gain_we) begin
      gain_reg <= gain;
    end
  end

  // Datapath: latch, multiply, accumulate, divide
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_est  <= '0;
      abs_acc <= '0;
    end else begin
      if (state == BK_CALC) begin
        dc_est <= dc_next;
      end
      if (state == BK_ACCUM) begin
        abs_acc <= cur.last ? '0 : abs_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
    if (state == BK_CALC) begin
      prod <= PROD_W'(centered * $signed({1'b0, gain_reg}));
    end
    if (state == BK_ACCUM) begin
      amp     <= amp_next;
      dvd     <= abs_next;
      rem     <= '0;
      divisor <= cur.count;
      div_cnt <= '0;
    end
    if (state == BK_DIVIDE) begin
      rem     <= trial_ge ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
      dvd     <= {dvd[ACC_W-2:0], trial_ge};
      div_cnt <= div_cnt + DCNT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_out <= amp;
      frame_done <= cur.last;
      if (cur.last) begin
        frame_min       <= cur.fmin;
        frame_max       <= cur.fmax;
        frame_delta_sum <= cur.delta;
        frame_mean_abs  <= dvd[SAMPLE_W-1:0];
      end else begin
        frame_min       <= '0;
        frame_max       <= '0;
        frame_delta_sum <= '0;
        frame_mean_abs  <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mic_dc_removal_gain_frame_stats.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mic_dc_removal_gain_frame_stats
// Microphone DC blocker with gain, saturation and per-frame statistics.
// ----------------------------------------------------------------------------
// The front takes one sample per cycle into a QUEUE_DEPTH-entry queue while
// there is room, tracking raw min/max, neighbor deltas and the frame count as
// it goes. The back takes one queued sample at a time through pop, DC update
// with the gain multiply, saturate and accumulate, and load of the result
// register, popping the next only after that load. The last sample of a frame
// also runs the serial mean divider before its load. One result per sample is
// held in the result register until popped; the back waits to load the next.
// ----------------------------------------------------------------------------
module mic_dc_removal_gain_frame_stats #(
  parameter int MAX_FRAME   = mdcr_pkg::DEF_MAX_FRAME,
  parameter int QUEUE_DEPTH = mdcr_pkg::DEF_Q_DEPTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 gain_we,
  input  wire logic [mdcr_pkg::GAIN_W-1:0]          gain,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic signed [mdcr_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic                                 frame_last,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic signed [mdcr_pkg::SAMPLE_W-1:0]      sample_out,
  output logic                                      frame_done,
  output logic signed [mdcr_pkg::SAMPLE_W-1:0]      frame_min,
  output logic signed [mdcr_pkg::SAMPLE_W-1:0]      frame_max,
  output logic [mdcr_pkg::ACC_W-1:0]                frame_delta_sum,
  output logic [mdcr_pkg::SAMPLE_W-1:0]             frame_mean_abs
);
  import mdcr_pkg::*;

  entry_t              fr_entry;
  entry_t              bk_entry;
  logic [ENTRY_W-1:0]  head_bits;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;

  assign bk_entry = entry_t'(head_bits);

  // Accept and classify samples
  mdcr_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample_in  (sample_in),
    .frame_last (frame_last),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (fr_entry)
  );

  // Decouple front and back
  mdcr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (fr_entry),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (head_bits),
    .q_empty (q_empty)
  );

  // Process samples and produce results
  mdcr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .gain_we         (gain_we),
    .gain            (gain),
    .q_entry         (bk_entry),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .sample_out      (sample_out),
    .frame_done      (frame_done),
    .frame_min       (frame_min),
    .frame_max       (frame_max),
    .frame_delta_sum (frame_delta_sum),
    .frame_mean_abs  (frame_mean_abs)
  );

endmodule
`default_nettype wire
